/* hdl/quad_facet_area_four_point_assert.svh */
// Assertion macros shared by the facet area block.
`ifndef QUAD_FACET_AREA_FOUR_POINT_ASSERT_SVH
`define QUAD_FACET_AREA_FOUR_POINT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define QFA_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qfa assertion failed");

// Next-cycle implication, disabled while in reset.
`define QFA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qfa assertion failed");

`endif

/* hdl/qfa_pkg.sv */
package qfa_pkg;

    localparam int WEIGHT_W   = 31;
    localparam logic [WEIGHT_W-1:0] WEIGHT_A = 31'd453816693;
    localparam logic [WEIGHT_W-1:0] WEIGHT_B = 31'd1693666955;
    localparam int TAN_SHIFT  = 24;
    localparam int GUARD_BITS = 8;
    localparam int AREA_W     = 64;
    localparam int AREA_FRAC  = 24;
    localparam int LIMB_W     = 16;

    typedef struct packed {
        logic en;
        logic vld;
    } pipe_ctl_t;

endpackage

/* hdl/quad_facet_area_four_point.sv */
// Surface area of a bilinear quadrilateral facet by 2x2 Gauss quadrature.
// Input channel s_*: one word holds the twelve corner coordinates (corners
// 0..3, x/y/z each), signed fixed point with COORD_FRAC_BITS fraction bits.
// Result channel m_*: facet_area (unsigned Q40.24, saturating) and
// degenerate_flag, set when the area is zero.
// Throughput: one word per cycle, every cycle, while m_ready is high.
// The square root pipeline (one root bit per stage) is the longest part of
// the path; the two limb-serial multiplier pipelines and the registered
// stages between them make up the rest.
// The pipeline advances as a whole whenever the output register is empty
// or is being taken; when the receiver stalls, every stage holds its word
// and s_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and holds s_ready low; the result channel is
// empty afterwards and the block accepts words from the first cycle after reset.
`include "quad_facet_area_four_point_assert.svh"

module quad_facet_area_four_point #(
    parameter int COORD_WIDTH     = 32,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_corner0_x,
    input  logic signed [COORD_WIDTH-1:0] s_corner0_y,
    input  logic signed [COORD_WIDTH-1:0] s_corner0_z,
    input  logic signed [COORD_WIDTH-1:0] s_corner1_x,
    input  logic signed [COORD_WIDTH-1:0] s_corner1_y,
    input  logic signed [COORD_WIDTH-1:0] s_corner1_z,
    input  logic signed [COORD_WIDTH-1:0] s_corner2_x,
    input  logic signed [COORD_WIDTH-1:0] s_corner2_y,
    input  logic signed [COORD_WIDTH-1:0] s_corner2_z,
    input  logic signed [COORD_WIDTH-1:0] s_corner3_x,
    input  logic signed [COORD_WIDTH-1:0] s_corner3_y,
    input  logic signed [COORD_WIDTH-1:0] s_corner3_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [qfa_pkg::AREA_W-1:0]    m_facet_area,
    output logic                          m_degenerate_flag
);

    localparam int AW_OUT = qfa_pkg::AREA_W;
    localparam int DW     = COORD_WIDTH + 1;
    localparam int PW     = DW + qfa_pkg::WEIGHT_W + 1;
    localparam int SUMW   = PW + 1;
    localparam int TW     = SUMW - qfa_pkg::TAN_SHIFT;
    localparam int MW     = COORD_WIDTH + 8;
    localparam int XPW    = 2 * MW;
    localparam int DFW    = XPW + 2;
    localparam int CMW    = XPW + 1;
    localparam int SQW    = 2 * CMW;
    localparam int SSW    = SQW + 2;
    localparam int RW     = (SSW + 1) / 2;
    localparam int XW     = (RW > AW_OUT) ? RW : AW_OUT;
    localparam int ROOT_SHIFT =
        2 * (COORD_FRAC_BITS + qfa_pkg::GUARD_BITS) - qfa_pkg::AREA_FRAC;

    localparam logic signed [qfa_pkg::WEIGHT_W:0] WA_S = {1'b0, qfa_pkg::WEIGHT_A};
    localparam logic signed [qfa_pkg::WEIGHT_W:0] WB_S = {1'b0, qfa_pkg::WEIGHT_B};
    localparam logic signed [SUMW-1:0] HALF = SUMW'(1) << (qfa_pkg::TAN_SHIFT - 1);

    logic en;
    assign en      = m_ready | ~m_valid;
    assign s_ready = en & aresetn;

    logic signed [COORD_WIDTH-1:0] pin [4][3];
    assign pin[0][0] = s_corner0_x;
    assign pin[0][1] = s_corner0_y;
    assign pin[0][2] = s_corner0_z;
    assign pin[1][0] = s_corner1_x;
    assign pin[1][1] = s_corner1_y;
    assign pin[1][2] = s_corner1_z;
    assign pin[2][0] = s_corner2_x;
    assign pin[2][1] = s_corner2_y;
    assign pin[2][2] = s_corner2_z;
    assign pin[3][0] = s_corner3_x;
    assign pin[3][1] = s_corner3_y;
    assign pin[3][2] = s_corner3_z;

    // ---- edge differences: p1-p0, p2-p3, p3-p0, p2-p1 per axis
    logic signed [DW-1:0] d_next [3][4];
    logic signed [DW-1:0] d_reg  [3][4];
    logic                 r1_vld_reg;

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            d_next[ax][0] = DW'(pin[1][ax]) - DW'(pin[0][ax]);
            d_next[ax][1] = DW'(pin[2][ax]) - DW'(pin[3][ax]);
            d_next[ax][2] = DW'(pin[3][ax]) - DW'(pin[0][ax]);
            d_next[ax][3] = DW'(pin[2][ax]) - DW'(pin[1][ax]);
        end
    end

    // ---- weighted products: even index by weight a, odd by weight b
    logic signed [PW-1:0] prod_next [3][8];
    logic signed [PW-1:0] prod_reg  [3][8];
    logic                 r2_vld_reg;

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            for (int j = 0; j < 4; j++) begin
                prod_next[ax][2*j]   = PW'(d_reg[ax][j]) * PW'(WA_S);
                prod_next[ax][2*j+1] = PW'(d_reg[ax][j]) * PW'(WB_S);
            end
        end
    end

    // ---- tangents: 0 r(s+), 1 r(s-), 2 s(r+), 3 s(r-)
    function automatic logic signed [TW-1:0] round_tan(
        input logic signed [PW-1:0] x,
        input logic signed [PW-1:0] y
    );
        logic signed [SUMW-1:0] s;
        s = SUMW'(x) + SUMW'(y) + HALF;
        return TW'(s >>> qfa_pkg::TAN_SHIFT);
    endfunction

    logic signed [TW-1:0] tan_next [4][3];
    logic signed [TW-1:0] tan_reg  [4][3];
    logic                 r3_vld_reg;

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            tan_next[0][ax] = round_tan(prod_reg[ax][0], prod_reg[ax][3]);
            tan_next[1][ax] = round_tan(prod_reg[ax][1], prod_reg[ax][2]);
            tan_next[2][ax] = round_tan(prod_reg[ax][4], prod_reg[ax][7]);
            tan_next[3][ax] = round_tan(prod_reg[ax][5], prod_reg[ax][6]);
        end
    end

    // ---- magnitude and sign
    logic [MW-1:0] mag_next [4][3];
    logic [MW-1:0] mag_reg  [4][3];
    logic          sgn_reg  [4][3];
    logic          r4_vld_reg;

    always_comb begin
        for (int t = 0; t < 4; t++) begin
            for (int ax = 0; ax < 3; ax++) begin
                mag_next[t][ax] = MW'(tan_reg[t][ax][TW-1] ? -tan_reg[t][ax] : tan_reg[t][ax]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
            r3_vld_reg <= 1'b0;
            r4_vld_reg <= 1'b0;
        end else if (en) begin
            r1_vld_reg <= s_valid;
            r2_vld_reg <= r1_vld_reg;
            r3_vld_reg <= r2_vld_reg;
            r4_vld_reg <= r3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= d_next;
            prod_reg <= prod_next;
            tan_reg  <= tan_next;
            mag_reg  <= mag_next;
            for (int t = 0; t < 4; t++) begin
                for (int ax = 0; ax < 3; ax++) begin
                    sgn_reg[t][ax] <= tan_reg[t][ax][TW-1];
                end
            end
        end
    end

    // ---- cross product terms, points (r+,s+) (r-,s+) (r-,s-) (r+,s-)
    qfa_pkg::pipe_ctl_t xctl;
    assign xctl.en  = en;
    assign xctl.vld = r4_vld_reg;

    logic [XPW-1:0] xp [4][3][2];
    logic           xs [4][3][2];
    logic           xv [4][3][2];
    logic [23:0]    xv_all;

    for (genvar pt = 0; pt < 4; pt++) begin : g_pt
        localparam int TS = (pt < 2) ? 0 : 1;
        localparam int US = (pt == 0 || pt == 3) ? 2 : 3;
        for (genvar c = 0; c < 3; c++) begin : g_comp
            for (genvar h = 0; h < 2; h++) begin : g_half
                localparam int IA = (h == 0) ? (c + 1) % 3 : (c + 2) % 3;
                localparam int IB = (h == 0) ? (c + 2) % 3 : (c + 1) % 3;
                qfa_umul #(
                    .AW (MW),
                    .BW (MW)
                ) u_xmul (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .ctl      (xctl),
                    .a        (mag_reg[TS][IA]),
                    .b        (mag_reg[US][IB]),
                    .side_in  (sgn_reg[TS][IA] ^ sgn_reg[US][IB]),
                    .vld_out  (xv[pt][c][h]),
                    .p        (xp[pt][c][h]),
                    .side_out (xs[pt][c][h])
                );
                assign xv_all[pt*6 + c*2 + h] = xv[pt][c][h];
            end
        end
    end

    // ---- restore signs, then difference magnitude
    logic signed [XPW:0]   xsv_next [4][3][2];
    logic signed [XPW:0]   xsv_reg  [4][3][2];
    logic                  x1_vld_reg;
    logic signed [DFW-1:0] dif      [4][3];
    logic [CMW-1:0]        cm_next  [4][3];
    logic [CMW-1:0]        cm_reg   [4][3];
    logic                  x2_vld_reg;

    always_comb begin
        for (int pt = 0; pt < 4; pt++) begin
            for (int c = 0; c < 3; c++) begin
                for (int h = 0; h < 2; h++) begin
                    xsv_next[pt][c][h] = xs[pt][c][h] ? -signed'({1'b0, xp[pt][c][h]})
                                                      :  signed'({1'b0, xp[pt][c][h]});
                end
                dif[pt][c]     = DFW'(xsv_reg[pt][c][0]) - DFW'(xsv_reg[pt][c][1]);
                cm_next[pt][c] = CMW'(dif[pt][c][DFW-1] ? -dif[pt][c] : dif[pt][c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_vld_reg <= 1'b0;
            x2_vld_reg <= 1'b0;
        end else if (en) begin
            x1_vld_reg <= xv[0][0][0];
            x2_vld_reg <= x1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xsv_reg <= xsv_next;
            cm_reg  <= cm_next;
        end
    end

    // ---- squares of the cross product components
    qfa_pkg::pipe_ctl_t sqctl;
    assign sqctl.en  = en;
    assign sqctl.vld = x2_vld_reg;

    logic [SQW-1:0] sq  [4][3];
    logic           sqv [4][3];
    logic           sqs [4][3];
    logic [11:0]    sqv_all;

    for (genvar pt = 0; pt < 4; pt++) begin : g_sq_pt
        for (genvar c = 0; c < 3; c++) begin : g_sq_comp
            qfa_umul #(
                .AW (CMW),
                .BW (CMW)
            ) u_sqmul (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (sqctl),
                .a        (cm_reg[pt][c]),
                .b        (cm_reg[pt][c]),
                .side_in  (1'b0),
                .vld_out  (sqv[pt][c]),
                .p        (sq[pt][c]),
                .side_out (sqs[pt][c])
            );
            assign sqv_all[pt*3 + c] = sqv[pt][c] & ~sqs[pt][c];
        end
    end

    // ---- Gram value per point
    logic [SSW-1:0] ss_next [4];
    logic [SSW-1:0] ss_reg  [4];
    logic           ss_vld_reg;

    always_comb begin
        for (int pt = 0; pt < 4; pt++) begin
            ss_next[pt] = SSW'(sq[pt][0]) + SSW'(sq[pt][1]) + SSW'(sq[pt][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ss_vld_reg <= 1'b0;
        end else if (en) begin
            ss_vld_reg <= sqv[0][0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ss_reg <= ss_next;
        end
    end

    // ---- square roots
    qfa_pkg::pipe_ctl_t rtctl;
    assign rtctl.en  = en;
    assign rtctl.vld = ss_vld_reg;

    logic [RW-1:0] root [4];
    logic          rv   [4];
    logic [3:0]    rv_all;

    for (genvar pt = 0; pt < 4; pt++) begin : g_root
        qfa_isqrt #(
            .NW (SSW)
        ) u_isqrt (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (rtctl),
            .n       (ss_reg[pt]),
            .vld_out (rv[pt]),
            .root    (root[pt])
        );
        assign rv_all[pt] = rv[pt];
    end

    // ---- scale, saturate and sum into the output register
    logic [XW-1:0]     sh   [4];
    logic [AW_OUT-1:0] pv   [4];
    logic [AW_OUT+1:0] total;
    logic [AW_OUT-1:0] area_next;

    always_comb begin
        total = '0;
        for (int pt = 0; pt < 4; pt++) begin
            sh[pt] = XW'(root[pt] >> ROOT_SHIFT);
            pv[pt] = ((sh[pt] >> AW_OUT) != '0) ? '1 : sh[pt][AW_OUT-1:0];
            total  = total + (AW_OUT+2)'(pv[pt]);
        end
        area_next = (total[AW_OUT+1:AW_OUT] != 2'b00) ? '1 : total[AW_OUT-1:0];
    end

    logic                m_valid_reg;
    logic [AW_OUT-1:0]   m_area_reg;
    logic                m_flag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= rv[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_area_reg <= area_next;
            m_flag_reg <= (area_next == '0);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_facet_area      = m_area_reg;
    assign m_degenerate_flag = m_flag_reg;

    // lanes of each multiplier and root array move in lock step
    `QFA_ASSERT_IMPL(a_cross_lanes_aligned, aclk, aresetn, xv_all != '0, xv_all == '1)
    `QFA_ASSERT_IMPL(a_square_lanes_aligned, aclk, aresetn, sqv_all != '0, sqv_all == '1)
    `QFA_ASSERT_IMPL(a_root_lanes_aligned, aclk, aresetn, rv_all != '0, rv_all == '1)
    // four zero roots must give a degenerate result word
    `QFA_ASSERT_NEXT(a_zero_roots_flag, aclk, aresetn, en && rv[0] && root[0] == '0 && root[1] == '0 && root[2] == '0 && root[3] == '0, m_valid && m_degenerate_flag)

endmodule

/* hdl/qfa_umul.sv */
module qfa_umul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  qfa_pkg::pipe_ctl_t    ctl,
    input  logic [AW-1:0]         a,
    input  logic [BW-1:0]         b,
    input  logic                  side_in,
    output logic                  vld_out,
    output logic [AW+BW-1:0]      p,
    output logic                  side_out
);

    localparam int LW  = qfa_pkg::LIMB_W;
    localparam int NL  = (BW + LW - 1) / LW;
    localparam int BPW = NL * LW;
    localparam int PW  = AW + BW;

    logic [PW-1:0]  acc_reg  [NL];
    logic [AW-1:0]  a_reg    [NL];
    logic [BPW-1:0] b_reg    [NL];
    logic           side_reg [NL];
    logic           vld_reg  [NL];

    for (genvar i = 0; i < NL; i++) begin : g_stage
        logic [PW-1:0]    acc_src;
        logic [AW-1:0]    a_src;
        logic [BPW-1:0]   b_src;
        logic             side_src;
        logic             vld_src;
        logic [AW+LW-1:0] pp;
        logic [PW-1:0]    acc_next;

        if (i == 0) begin : g_first
            assign acc_src  = '0;
            assign a_src    = a;
            assign b_src    = BPW'(b);
            assign side_src = side_in;
            assign vld_src  = ctl.vld;
        end else begin : g_next
            assign acc_src  = acc_reg[i-1];
            assign a_src    = a_reg[i-1];
            assign b_src    = b_reg[i-1];
            assign side_src = side_reg[i-1];
            assign vld_src  = vld_reg[i-1];
        end

        // one limb of b per stage
        assign pp       = a_src * b_src[i*LW +: LW];
        assign acc_next = acc_src + (PW'(pp) << (i * LW));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (ctl.en) begin
                vld_reg[i] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.en) begin
                acc_reg[i]  <= acc_next;
                a_reg[i]    <= a_src;
                b_reg[i]    <= b_src;
                side_reg[i] <= side_src;
            end
        end
    end

    assign p        = acc_reg[NL-1];
    assign side_out = side_reg[NL-1];
    assign vld_out  = vld_reg[NL-1];

endmodule

/* hdl/qfa_isqrt.sv */
module qfa_isqrt #(
    parameter int NW = 164
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  qfa_pkg::pipe_ctl_t     ctl,
    input  logic [NW-1:0]          n,
    output logic                   vld_out,
    output logic [(NW+1)/2-1:0]    root
);

    localparam int RW   = (NW + 1) / 2;
    localparam int NPW  = 2 * RW;
    localparam int REMW = RW + 2;

    logic [REMW-1:0] rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [NPW-1:0]  n_reg    [RW];
    logic            vld_reg  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [REMW-1:0] rem_src;
        logic [RW-1:0]   root_src;
        logic [NPW-1:0]  n_src;
        logic            vld_src;
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        logic            ge;
        logic [REMW-1:0] rem_next;
        logic [RW-1:0]   root_next;

        if (k == 0) begin : g_first
            assign rem_src  = '0;
            assign root_src = '0;
            assign n_src    = NPW'(n);
            assign vld_src  = ctl.vld;
        end else begin : g_next
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign n_src    = n_reg[k-1];
            assign vld_src  = vld_reg[k-1];
        end

        // bring down the next two bits, try root bit one
        assign rem_sh    = {rem_src[REMW-3:0], n_src[NPW-1 -: 2]};
        assign trial     = {root_src, 2'b01};
        assign ge        = rem_sh >= trial;
        assign rem_next  = ge ? rem_sh - trial : rem_sh;
        assign root_next = {root_src[RW-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ctl.en) begin
                vld_reg[k] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                n_reg[k]    <= n_src << 2;
            end
        end
    end

    assign root    = root_reg[RW-1];
    assign vld_out = vld_reg[RW-1];

endmodule
